FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PAI_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define PAI_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: sv/pai_pkg.sv
// Shared types, codes and widths of the positional array core.
`default_nettype none

package pai_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int VALUE_W  = 32;
	localparam int OPCODE_W = 2;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_DELETE   = 2'd1,
		OP_SEARCH   = 2'd2,
		OP_TRAVERSE = 2'd3
	} opcode_t;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_FULL     = 3'd1;
	localparam status_t ST_EMPTY    = 3'd2;
	localparam status_t ST_BADPOS   = 3'd3;
	localparam status_t ST_NOTFOUND = 3'd4;

	// What every cell does in the current cycle.
	typedef enum logic [1:0] {
		ACT_HOLD   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_ROTATE = 2'd3
	} cell_act_t;

	typedef struct packed {
		cell_act_t                  act;
		logic signed [VALUE_W-1:0]  value;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/pai_cell.sv
// One storage cell of the element chain: shift, load, rotate and compare.
`default_nettype none

module pai_cell #(
	parameter int CAPACITY = pai_pkg::CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  logic                              clk,
	input  pai_pkg::cell_ctl_t                ctl,
	input  logic [$clog2(CAPACITY+1)-1:0]     pos,
	input  logic [$clog2(CAPACITY+1)-1:0]     count,
	input  logic signed [pai_pkg::VALUE_W-1:0] left_d,
	input  logic signed [pai_pkg::VALUE_W-1:0] right_d,
	input  logic signed [pai_pkg::VALUE_W-1:0] head_d,
	output logic signed [pai_pkg::VALUE_W-1:0] data,
	output logic                              match
);
	import pai_pkg::*;

	localparam int CW = $clog2(CAPACITY+1);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [CW-1:0] IDX_N = CW'(IDX + 1);

	logic signed [VALUE_W-1:0] data_q;
	logic signed [VALUE_W-1:0] data_nxt;

	always_comb begin
		data_nxt = data_q;
		case (ctl.act)
			ACT_INSERT: begin
				if (IDX_C == pos) begin
					data_nxt = ctl.value;
				end else if (IDX_C > pos && IDX_C <= count) begin
					data_nxt = left_d;
				end
			end
			ACT_DELETE: begin
				if (IDX_C >= pos && IDX_N < count) begin
					data_nxt = right_d;
				end
			end
			ACT_ROTATE: begin
				// last live cell takes the head word, the rest move down
				if (IDX_N == count) begin
					data_nxt = head_d;
				end else if (IDX_N < count) begin
					data_nxt = right_d;
				end
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data  = data_q;
	assign match = (IDX_C < count) && (data_q == ctl.value);

endmodule

`default_nettype wire

FILE: sv/pai_find.sv
// Find-first over the registered match vector of the cell chain.
`default_nettype none

module pai_find #(
	parameter int CAPACITY = pai_pkg::CAPACITY_DEF
) (
	input  logic [CAPACITY-1:0]         match,
	output logic                        hit,
	output logic [$clog2(CAPACITY)-1:0] idx
);
	import pai_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	always_comb begin
		idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				idx = IW'(i);
			end
		end
	end

	assign hit = |match;

endmodule

`default_nettype wire

FILE: sv/positional_array_insert_delete_search_core.sv
// Top level of the positional array core: controller, cell chain, output register.
//
//   channel | direction | handshake          | fields
//   in      | input     | in_valid/in_stall  | opcode, item_value, position
//   out     | output    | out_valid/out_stall| status, found_index, element_out,
//           |           |                    | count_now, last
//
// Insert and delete: accept, then one broadcast to all cells once the output is free.
// Search: cells compare into the registered match vector, then the find-first stage encodes the hit.
// Traverse: the chain rotates one word per cycle out of cell 0 while the output is not stalled.
// Reset clears the count and the control state; cell contents are not cleared.
// A stalled output holds the step that loads the result word; one word is in work at a time.
`default_nettype none

module positional_array_insert_delete_search_core #(
	parameter int CAPACITY = pai_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pai_pkg::OPCODE_W-1:0]       opcode,
	input  logic signed [pai_pkg::VALUE_W-1:0] item_value,
	input  logic [pai_pkg::POS_W-1:0]          position,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pai_pkg::STATUS_W-1:0]       status,
	output logic [pai_pkg::INDEX_W-1:0]        found_index,
	output logic signed [pai_pkg::VALUE_W-1:0] element_out,
	output logic [pai_pkg::COUNT_W-1:0]        count_now,
	output logic                               last
);
	import pai_pkg::*;

	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int IW    = $clog2(CAPACITY);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIND = 2'd2;
	localparam logic [1:0] S_TRAV = 2'd3;

	logic [1:0]                state_q, state_nxt;
	logic [CW-1:0]             count_q, count_nxt;
	logic [IW-1:0]             trav_q, trav_nxt;

	opcode_t                   op_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic [POS_W-1:0]          pos_s1;
	logic [CAPACITY-1:0]       match_q;

	logic                      out_valid_q;
	status_t                   status_q;
	logic [INDEX_W-1:0]        index_q;
	logic signed [VALUE_W-1:0] elem_q;
	logic [COUNT_W-1:0]        count_now_q;
	logic                      last_q;

	cell_ctl_t                 ctl;
	cell_act_t                 act;
	logic                      out_free;
	logic                      out_load;
	logic                      match_ld;
	status_t                   o_status;
	logic [INDEX_W-1:0]        o_index;
	logic signed [VALUE_W-1:0] o_elem;
	logic                      o_last;

	logic [CMP_W-1:0]          pos_x, cnt_x;
	logic                      ins_full, ins_bad, del_empty, del_bad;

	logic signed [VALUE_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]       match_w;
	logic                      find_hit;
	logic [IW-1:0]             find_idx;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign pos_x     = CMP_W'(pos_s1);
	assign cnt_x     = CMP_W'(count_q);
	assign ins_full  = (count_q == CW'(CAPACITY));
	assign ins_bad   = (pos_x > cnt_x);
	assign del_empty = (count_q == '0);
	assign del_bad   = (pos_x >= cnt_x);

	always_comb begin
		state_nxt = state_q;
		count_nxt = count_q;
		trav_nxt  = trav_q;
		act       = ACT_HOLD;
		out_load  = 1'b0;
		match_ld  = 1'b0;
		o_status  = ST_OK;
		o_index   = '0;
		o_elem    = '0;
		o_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_s1)
					OP_INSERT: begin
						if (out_free) begin
							out_load  = 1'b1;
							state_nxt = S_IDLE;
							if (ins_full) begin
								o_status = ST_FULL;
							end else if (ins_bad) begin
								o_status = ST_BADPOS;
							end else begin
								act       = ACT_INSERT;
								count_nxt = count_q + 1'b1;
							end
						end
					end
					OP_DELETE: begin
						if (out_free) begin
							out_load  = 1'b1;
							state_nxt = S_IDLE;
							if (del_empty) begin
								o_status = ST_EMPTY;
							end else if (del_bad) begin
								o_status = ST_BADPOS;
							end else begin
								act       = ACT_DELETE;
								count_nxt = count_q - 1'b1;
							end
						end
					end
					OP_SEARCH: begin
						match_ld  = 1'b1;
						state_nxt = S_FIND;
					end
					default: begin
						if (del_empty) begin
							if (out_free) begin
								out_load  = 1'b1;
								o_status  = ST_EMPTY;
								state_nxt = S_IDLE;
							end
						end else begin
							trav_nxt  = '0;
							state_nxt = S_TRAV;
						end
					end
				endcase
			end
			S_FIND: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = S_IDLE;
					if (find_hit) begin
						o_index = INDEX_W'(find_idx);
					end else begin
						o_status = ST_NOTFOUND;
					end
				end
			end
			S_TRAV: begin
				if (out_free) begin
					// emit the head word and rotate the chain by one
					out_load = 1'b1;
					act      = ACT_ROTATE;
					o_elem   = cell_data[0];
					o_index  = INDEX_W'(trav_q);
					o_last   = ((CW'(trav_q) + CW'(1)) == count_q);
					if (o_last) begin
						state_nxt = S_IDLE;
					end else begin
						trav_nxt = trav_q + 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			trav_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			trav_q  <= trav_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= opcode_t'(opcode);
			value_s1 <= item_value;
			pos_s1   <= position;
		end
		if (match_ld) begin
			match_q <= match_w;
		end
		if (out_load) begin
			status_q    <= o_status;
			index_q     <= o_index;
			elem_q      <= o_elem;
			count_now_q <= COUNT_W'(count_nxt);
			last_q      <= o_last;
		end
	end

	assign ctl = '{act: act, value: value_s1};

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VALUE_W-1:0] left_w;
		logic signed [VALUE_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_end
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		pai_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (g)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.pos     (CW'(pos_s1)),
			.count   (count_q),
			.left_d  (left_w),
			.right_d (right_w),
			.head_d  (cell_data[0]),
			.data    (cell_data[g]),
			.match   (match_w[g])
		);
	end

	pai_find #(
		.CAPACITY (CAPACITY)
	) u_find (
		.match (match_q),
		.hit   (find_hit),
		.idx   (find_idx)
	);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = index_q;
	assign element_out = elem_q;
	assign count_now   = count_now_q;
	assign last        = last_q;

endmodule

`default_nettype wire

FILE: sv/pai_checker.sv
// Port-level checks of the positional array core and their bind.
`default_nettype none
`include "assert_macros.svh"

module pai_checker #(
	parameter int CAPACITY = pai_pkg::CAPACITY_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [pai_pkg::STATUS_W-1:0]       status,
	input logic [pai_pkg::INDEX_W-1:0]        found_index,
	input logic signed [pai_pkg::VALUE_W-1:0] element_out,
	input logic [pai_pkg::COUNT_W-1:0]        count_now,
	input logic                               last
);
	import pai_pkg::*;

	// a stalled result word holds
	`PAI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(element_out) && $stable(last), "stalled result word changed")

	// one word in work at a time: the cycle after an accept refuses input
	`PAI_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input taken while busy")

	// any refusal or miss ends its item
	`PAI_ASSERT_NOW(a_err_last, out_valid && status != ST_OK, last, "error status without last")

	`PAI_ASSERT_NOW(a_miss_index, out_valid && status == ST_NOTFOUND, found_index == '0 && element_out == '0, "search miss carries data")

	`PAI_ASSERT_NOW(a_count_cap, out_valid, int'(count_now) <= CAPACITY, "count above capacity")

endmodule

bind positional_array_insert_delete_search_core pai_checker #(
	.CAPACITY (CAPACITY)
) u_pai_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.found_index (found_index),
	.element_out (element_out),
	.count_now   (count_now),
	.last        (last)
);

`default_nettype wire
